### rtl/grc_pkg.sv
package grc_pkg;

    // Fixed field widths
    localparam int COL_W      = 11;
    localparam int WALLS_W    = 8;
    localparam int IDX_W      = 8;
    localparam int DIST_W     = 16;
    localparam int TEX_W      = 8;
    localparam int HEIGHT_W   = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 56;
    localparam int MAP_DEPTH  = 256;

    // Datapath widths
    localparam int DIV_NUM_W = 26;
    localparam int DIV_DEN_W = 30;
    localparam int SCAN_W    = 27;
    localparam int RAY_W     = 30;
    localparam int MUL_A_W   = 17;
    localparam int MUL_B_W   = 30;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;

    // Parameter defaults
    localparam int GRID_SIDE_DEF    = 16;
    localparam int MAX_STEPS_DEF    = 32;
    localparam int HEIGHT_SCALE_DEF = 1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_POS_X, REG_POS_Y, REG_DIR_X, REG_DIR_Y,
        REG_PLANE_X, REG_PLANE_Y, REG_VIEW_WIDTH, REG_VIEW_HEIGHT
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CAST_HIT = 2'd0, CAST_LEFT_GRID = 2'd1, CAST_STEP_LIMIT = 2'd2
    } t_cast_status;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CAST_INIT, OP_SCAN_DIV, OP_SCAN_SAVE,
        OP_MUL_RX, OP_SAVE_RX, OP_MUL_RY, OP_SAVE_RY,
        OP_DX_INF, OP_DX_DIV, OP_DX_SAVE, OP_DY_INF, OP_DY_DIV, OP_DY_SAVE,
        OP_MUL_SX, OP_SAVE_SX, OP_MUL_SY, OP_SAVE_SY,
        OP_WALK_READ, OP_WALK_STEP, OP_HIT, OP_FAIL_GRID, OP_FAIL_STEPS,
        OP_MUL_TEX, OP_SAVE_TEX, OP_HT_MAX, OP_HT_DIV, OP_HT_SAVE, OP_EMIT
    } t_op;

    typedef struct packed {
        logic div_done;
        logic rx_zero;
        logic ry_zero;
        logic out_grid;
        logic steps_done;
        logic cell_hit;
        logic dist_zero;
    } t_dp_status;

endpackage

### rtl/grc_divider.sv
module grc_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [grc_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [grc_pkg::DIV_DEN_W-1:0] i_den,
    output logic                          o_done,
    output logic [grc_pkg::DIV_NUM_W-1:0] o_quot
);
    import grc_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_NUM_W-1:0] r_quot;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W:0]   r_rem;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_DEN_W:0]   w_shift;
    logic                 w_ge;

    // one quotient bit per cycle, restoring
    assign w_shift = {r_rem[DIV_DEN_W-1:0], r_num[DIV_NUM_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quot <= '0;
                r_cnt  <= CNT_W'(DIV_NUM_W);
            end else if (r_busy) begin
                r_rem  <= w_ge ? (w_shift - {1'b0, r_den}) : w_shift;
                r_quot <= {r_quot[DIV_NUM_W-2:0], w_ge};
                r_num  <= {r_num[DIV_NUM_W-2:0], 1'b0};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### rtl/grc_datapath.sv
module grc_datapath #(
    parameter int GRID_SIDE    = grc_pkg::GRID_SIDE_DEF,
    parameter int MAX_STEPS    = grc_pkg::MAX_STEPS_DEF,
    parameter int HEIGHT_SCALE = grc_pkg::HEIGHT_SCALE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  grc_pkg::t_op                   i_op,
    output grc_pkg::t_dp_status            o_status,
    input  logic                           i_cfg_we,
    input  logic [grc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [grc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [grc_pkg::IDX_W-1:0]      i_cell_index,
    input  logic [grc_pkg::WALLS_W-1:0]    i_cell_walls,
    input  logic [grc_pkg::COL_W-1:0]      i_column,
    output logic [grc_pkg::OUT_DATA_W-1:0] o_result
);
    import grc_pkg::*;

    localparam int SIDE_W = 17 + $clog2(MAX_STEPS + 1);
    localparam int STEP_W = $clog2(MAX_STEPS + 1);
    localparam int CRD_W  = $clog2(GRID_SIDE + MAX_STEPS + 1) + 1;
    localparam int ADDR_W = 2 * CRD_W;

    // configuration registers
    logic [11:0]        r_pos_x, r_pos_y;
    logic signed [15:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic [10:0]        r_vw;
    logic [9:0]         r_vh;

    // map store
    logic [WALLS_W-1:0] r_mem [MAP_DEPTH];
    logic [WALLS_W-1:0] r_rdata;

    // ray state
    logic [COL_W-1:0]          r_col;
    logic signed [SCAN_W-1:0]  r_scan;
    logic signed [RAY_W-1:0]   r_rx, r_ry;
    logic [DIST_W-1:0]         r_dx, r_dy;
    logic                      r_inf_x, r_inf_y;
    logic [SIDE_W-1:0]         r_sx, r_sy;
    logic signed [CRD_W-1:0]   r_mx, r_my;
    logic [STEP_W-1:0]         r_steps;
    logic                      r_xs;
    logic signed [PROD_W-1:0]  r_prod;

    // result fields
    logic [1:0]          r_code;
    logic                r_side;
    logic [DIST_W-1:0]   r_dist;
    logic [TEX_W-1:0]    r_tex;
    logic [HEIGHT_W-1:0] r_height;
    logic [1:0]          r_status;
    logic [OUT_DATA_W-1:0] r_result;

    // combinational helpers
    logic                      w_div_start, w_div_done;
    logic [DIV_NUM_W-1:0]      w_div_num, w_div_quot;
    logic [DIV_DEN_W-1:0]      w_div_den;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic [ADDR_W-1:0]         w_addr;
    logic                      w_xs;
    logic [1:0]                w_face;
    logic [8:0]                w_fx, w_fy;
    logic [DIST_W-1:0]         w_dq;
    logic [DIST_W-1:0]         w_dsat;
    logic [SIDE_W-1:0]         w_dist_raw;
    logic                      w_dist_inf;

    grc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // select divider operands
    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = '0;
        case (i_op)
            OP_SCAN_DIV: begin
                w_div_start = 1'b1;
                w_div_num   = {r_col, 15'b0};
                w_div_den   = (r_vw == '0) ? DIV_DEN_W'(1) : DIV_DEN_W'(r_vw);
            end
            OP_DX_DIV: begin
                w_div_start = 1'b1;
                w_div_num   = DIV_NUM_W'(1) << 22;
                w_div_den   = r_rx[RAY_W-1] ? DIV_DEN_W'(-r_rx) : DIV_DEN_W'(r_rx);
            end
            OP_DY_DIV: begin
                w_div_start = 1'b1;
                w_div_num   = DIV_NUM_W'(1) << 22;
                w_div_den   = r_ry[RAY_W-1] ? DIV_DEN_W'(-r_ry) : DIV_DEN_W'(r_ry);
            end
            OP_HT_DIV: begin
                w_div_start = 1'b1;
                w_div_num   = DIV_NUM_W'(HEIGHT_SCALE * 32'(r_vh)) << 8;
                w_div_den   = DIV_DEN_W'(r_dist);
            end
            default: ;
        endcase
    end

    // first crossing fractions
    assign w_fx = r_rx[RAY_W-1] ? {1'b0, r_pos_x[7:0]} : 9'd256 - {1'b0, r_pos_x[7:0]};
    assign w_fy = r_ry[RAY_W-1] ? {1'b0, r_pos_y[7:0]} : 9'd256 - {1'b0, r_pos_y[7:0]};

    // select multiplier operands
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_op)
            OP_MUL_RX: begin
                w_mul_a = MUL_A_W'(r_plane_x);
                w_mul_b = MUL_B_W'(r_scan);
            end
            OP_MUL_RY: begin
                w_mul_a = MUL_A_W'(r_plane_y);
                w_mul_b = MUL_B_W'(r_scan);
            end
            OP_MUL_SX: begin
                w_mul_a = MUL_A_W'(w_fx);
                w_mul_b = MUL_B_W'(r_dx);
            end
            OP_MUL_SY: begin
                w_mul_a = MUL_A_W'(w_fy);
                w_mul_b = MUL_B_W'(r_dy);
            end
            OP_MUL_TEX: begin
                w_mul_a = MUL_A_W'(r_dist);
                w_mul_b = r_side ? r_rx : r_ry;
            end
            default: ;
        endcase
    end

    // walk helpers
    assign w_addr = ADDR_W'($unsigned(r_my)) * ADDR_W'(GRID_SIDE) + ADDR_W'($unsigned(r_mx));
    assign w_xs   = !r_inf_x && (r_inf_y || (r_sx < r_sy));
    assign w_face = r_xs ? (r_rx[RAY_W-1] ? r_rdata[1:0] : r_rdata[5:4])
                         : (r_ry[RAY_W-1] ? r_rdata[3:2] : r_rdata[7:6]);
    assign w_dist_raw = r_xs ? r_sx : r_sy;
    assign w_dist_inf = r_xs ? r_inf_x : r_inf_y;
    assign w_dsat = (w_dist_inf || (w_dist_raw > SIDE_W'(16'hFFFF))) ? 16'hFFFF
                                                                     : w_dist_raw[DIST_W-1:0];
    assign w_dq   = (w_div_quot > DIV_NUM_W'(16'hFFFF)) ? 16'hFFFF : w_div_quot[DIST_W-1:0];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= 12'd384;
            r_pos_y   <= 12'd384;
            r_dir_x   <= 16'sd16384;
            r_dir_y   <= 16'sd0;
            r_plane_x <= 16'sd0;
            r_plane_y <= 16'sd10813;
            r_vw      <= 11'd640;
            r_vh      <= 10'd480;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_POS_X:       r_pos_x   <= i_cfg_data[11:0];
                REG_POS_Y:       r_pos_y   <= i_cfg_data[11:0];
                REG_DIR_X:       r_dir_x   <= i_cfg_data;
                REG_DIR_Y:       r_dir_y   <= i_cfg_data;
                REG_PLANE_X:     r_plane_x <= i_cfg_data;
                REG_PLANE_Y:     r_plane_y <= i_cfg_data;
                REG_VIEW_WIDTH:  r_vw      <= i_cfg_data[10:0];
                REG_VIEW_HEIGHT: r_vh      <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // map store port
    always_ff @(posedge i_clk) begin
        if (i_op == OP_LOAD) begin
            r_mem[i_cell_index] <= i_cell_walls;
        end
        if (i_op == OP_WALK_READ) begin
            r_rdata <= r_mem[w_addr[IDX_W-1:0]];
        end
    end

    // ray datapath
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        case (i_op)
            OP_CAST_INIT: begin
                r_col    <= i_column;
                r_mx     <= CRD_W'(r_pos_x[11:8]);
                r_my     <= CRD_W'(r_pos_y[11:8]);
                r_steps  <= '0;
                r_inf_x  <= 1'b0;
                r_inf_y  <= 1'b0;
                r_code   <= '0;
                r_side   <= 1'b0;
                r_dist   <= '0;
                r_tex    <= '0;
                r_height <= '0;
            end
            OP_SCAN_SAVE: r_scan <= $signed({1'b0, w_div_quot}) - SCAN_W'(16384);
            OP_SAVE_RX:   r_rx   <= RAY_W'(r_dir_x) + r_prod[RAY_W+13:14];
            OP_SAVE_RY:   r_ry   <= RAY_W'(r_dir_y) + r_prod[RAY_W+13:14];
            OP_DX_INF:    r_inf_x <= 1'b1;
            OP_DY_INF:    r_inf_y <= 1'b1;
            OP_DX_SAVE:   r_dx   <= w_dq;
            OP_DY_SAVE:   r_dy   <= w_dq;
            OP_SAVE_SX:   r_sx   <= r_prod[SIDE_W+7:8];
            OP_SAVE_SY:   r_sy   <= r_prod[SIDE_W+7:8];
            OP_WALK_READ: r_xs   <= w_xs;
            OP_WALK_STEP: begin
                r_steps <= r_steps + 1'b1;
                if (r_xs) begin
                    if (!r_inf_x) r_sx <= r_sx + SIDE_W'(r_dx);
                    r_mx <= r_rx[RAY_W-1] ? r_mx - 1'b1 : r_mx + 1'b1;
                end else begin
                    if (!r_inf_y) r_sy <= r_sy + SIDE_W'(r_dy);
                    r_my <= r_ry[RAY_W-1] ? r_my - 1'b1 : r_my + 1'b1;
                end
            end
            OP_HIT: begin
                r_code   <= w_face;
                r_side   <= !r_xs;
                r_dist   <= w_dsat;
                r_status <= CAST_HIT;
            end
            OP_FAIL_GRID:  r_status <= CAST_LEFT_GRID;
            OP_FAIL_STEPS: r_status <= CAST_STEP_LIMIT;
            OP_SAVE_TEX: begin
                r_tex <= (r_side ? r_pos_x[7:0] : r_pos_y[7:0]) + r_prod[21:14];
            end
            OP_HT_MAX:  r_height <= 16'hFFFF;
            OP_HT_SAVE: r_height <= w_dq;
            OP_EMIT: begin
                r_result <= {r_status, r_height, r_tex, r_dist, r_side, r_code, r_col};
            end
            default: ;
        endcase
    end

    // status to the controller
    always_comb begin
        o_status.div_done   = w_div_done;
        o_status.rx_zero    = (r_rx == '0);
        o_status.ry_zero    = (r_ry == '0);
        o_status.out_grid   = r_mx < 0 || r_my < 0 || r_mx >= CRD_W'(GRID_SIDE)
                              || r_my >= CRD_W'(GRID_SIDE) || w_addr >= ADDR_W'(MAP_DEPTH);
        o_status.steps_done = (r_steps == STEP_W'(MAX_STEPS));
        o_status.cell_hit   = (w_face != 2'd0);
        o_status.dist_zero  = (r_dist == '0);
    end

    assign o_result = r_result;

endmodule

### rtl/grc_ctrl.sv
module grc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_req_cast,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  grc_pkg::t_dp_status i_status,
    output grc_pkg::t_op        o_op
);
    import grc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN, S_SCAN_WAIT, S_SCAN_SAVE, S_MUL_RX, S_SAVE_RX, S_MUL_RY, S_SAVE_RY,
        S_DX, S_DX_WAIT, S_DX_SAVE, S_DY, S_DY_WAIT, S_DY_SAVE,
        S_MUL_SX, S_SAVE_SX, S_MUL_SY, S_SAVE_SY, S_CHECK, S_EVAL,
        S_MUL_TEX, S_SAVE_TEX, S_HT, S_HT_WAIT, S_HT_SAVE, S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // next state and command
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_op        = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_req_cast) begin
                        o_op    = OP_CAST_INIT;
                        n_state = S_SCAN;
                    end else begin
                        o_op = OP_LOAD;
                    end
                end
            end
            S_SCAN: begin
                o_op    = OP_SCAN_DIV;
                n_state = S_SCAN_WAIT;
            end
            S_SCAN_WAIT: if (i_status.div_done) n_state = S_SCAN_SAVE;
            S_SCAN_SAVE: begin
                o_op    = OP_SCAN_SAVE;
                n_state = S_MUL_RX;
            end
            S_MUL_RX: begin
                o_op    = OP_MUL_RX;
                n_state = S_SAVE_RX;
            end
            S_SAVE_RX: begin
                o_op    = OP_SAVE_RX;
                n_state = S_MUL_RY;
            end
            S_MUL_RY: begin
                o_op    = OP_MUL_RY;
                n_state = S_SAVE_RY;
            end
            S_SAVE_RY: begin
                o_op    = OP_SAVE_RY;
                n_state = S_DX;
            end
            S_DX: begin
                if (i_status.rx_zero) begin
                    o_op    = OP_DX_INF;
                    n_state = S_DY;
                end else begin
                    o_op    = OP_DX_DIV;
                    n_state = S_DX_WAIT;
                end
            end
            S_DX_WAIT: if (i_status.div_done) n_state = S_DX_SAVE;
            S_DX_SAVE: begin
                o_op    = OP_DX_SAVE;
                n_state = S_DY;
            end
            S_DY: begin
                if (i_status.ry_zero) begin
                    o_op    = OP_DY_INF;
                    n_state = S_MUL_SX;
                end else begin
                    o_op    = OP_DY_DIV;
                    n_state = S_DY_WAIT;
                end
            end
            S_DY_WAIT: if (i_status.div_done) n_state = S_DY_SAVE;
            S_DY_SAVE: begin
                o_op    = OP_DY_SAVE;
                n_state = S_MUL_SX;
            end
            S_MUL_SX: begin
                o_op    = OP_MUL_SX;
                n_state = S_SAVE_SX;
            end
            S_SAVE_SX: begin
                o_op    = OP_SAVE_SX;
                n_state = S_MUL_SY;
            end
            S_MUL_SY: begin
                o_op    = OP_MUL_SY;
                n_state = S_SAVE_SY;
            end
            S_SAVE_SY: begin
                o_op    = OP_SAVE_SY;
                n_state = S_CHECK;
            end
            // step limit first, then the grid bounds, then read the cell
            S_CHECK: begin
                if (i_status.steps_done) begin
                    o_op    = OP_FAIL_STEPS;
                    n_state = S_EMIT;
                end else if (i_status.out_grid) begin
                    o_op    = OP_FAIL_GRID;
                    n_state = S_EMIT;
                end else begin
                    o_op    = OP_WALK_READ;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_status.cell_hit) begin
                    o_op    = OP_HIT;
                    n_state = S_MUL_TEX;
                end else begin
                    o_op    = OP_WALK_STEP;
                    n_state = S_CHECK;
                end
            end
            S_MUL_TEX: begin
                o_op    = OP_MUL_TEX;
                n_state = S_SAVE_TEX;
            end
            S_SAVE_TEX: begin
                o_op    = OP_SAVE_TEX;
                n_state = S_HT;
            end
            S_HT: begin
                if (i_status.dist_zero) begin
                    o_op    = OP_HT_MAX;
                    n_state = S_EMIT;
                end else begin
                    o_op    = OP_HT_DIV;
                    n_state = S_HT_WAIT;
                end
            end
            S_HT_WAIT: if (i_status.div_done) n_state = S_HT_SAVE;
            S_HT_SAVE: begin
                o_op    = OP_HT_SAVE;
                n_state = S_EMIT;
            end
            // hand the result over once the output register is free
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_op        = OP_EMIT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### rtl/grid_raycast_column.sv
// Channel   | Direction | Contents
// s_axis    | in        | tdata: cell_index, cell_walls, column; tuser: req_type
// m_axis    | out       | tdata: out_column .. cast_status, one per cast
// i_cfg_*   | in        | register write: index, data
//
// A cast uses the shared bit-serial divider for the scan position, the two step
// lengths and the height; each division is issued, waited on and saved, and a
// zero ray component or a zero distance skips that division. Accept, multiply
// and setup states come around these, and the map walk spends a check state and
// an evaluate state on each cell visited, as the map store has a registered port.
// Reset is synchronous and active low; the map store is not cleared.
// A finished result waits in the output register; a stalled output holds the
// block in its final state until that register frees up.
module grid_raycast_column #(
    parameter int GRID_SIDE    = grc_pkg::GRID_SIDE_DEF,
    parameter int MAX_STEPS    = grc_pkg::MAX_STEPS_DEF,
    parameter int HEIGHT_SCALE = grc_pkg::HEIGHT_SCALE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // cell_index[7:0], cell_walls[15:8], column[26:16], zero fill
    input  logic [grc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // req_type[0]
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_column[10:0], wall_code[12:11], hit_side[13], wall_distance[29:14],
    // texture_offset[37:30], wall_height[53:38], cast_status[55:54]
    output logic [grc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           i_cfg_we,
    input  logic [grc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [grc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import grc_pkg::*;

    t_op        w_op;
    t_dp_status w_status;

    grc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_req_cast  (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_op        (w_op)
    );

    grc_datapath #(
        .GRID_SIDE    (GRID_SIDE),
        .MAX_STEPS    (MAX_STEPS),
        .HEIGHT_SCALE (HEIGHT_SCALE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (w_op),
        .o_status     (w_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_cell_index (s_axis_tdata[7:0]),
        .i_cell_walls (s_axis_tdata[15:8]),
        .i_column     (s_axis_tdata[26:16]),
        .o_result     (m_axis_tdata)
    );

endmodule

### test/tb.sv
module tb;
    import grc_pkg::*;

    localparam bit      REQ_LOAD  = 1'b0;
    localparam bit      REQ_CAST  = 1'b1;
    localparam longint  RAY_INF   = longint'(1) << 40;
    localparam int      N_PHASES  = 8;
    localparam int      PHASE_LEN = 30;
    localparam int      SETTLE    = 300;
    localparam longint  CYCLE_CAP = 1000000;

    typedef struct {
        logic [10:0] column;
        logic [1:0]  code;
        logic        side;
        logic [15:0] distance;
        logic [7:0]  tex;
        logic [15:0] height;
        logic [1:0]  status;
    } cast_result_t;

    // Tracks map and camera state and the queue of casts still owed by the block
    class raycast_scoreboard;
        logic [7:0]   map_cells [MAP_DEPTH];
        longint       cam_x, cam_y, dir_x, dir_y, plane_x, plane_y, view_w, view_h;
        cast_result_t pending_casts[$];
        int           errors, casts_done, hits, misses;

        function new();
            cam_x = 384; cam_y = 384; dir_x = 16384; dir_y = 0;
            plane_x = 0; plane_y = 10813; view_w = 640; view_h = 480;
        endfunction

        function void write_reg(t_cfg_reg r, logic [15:0] v);
            case (r)
                REG_POS_X:       cam_x   = v[11:0];
                REG_POS_Y:       cam_y   = v[11:0];
                REG_DIR_X:       dir_x   = longint'($signed(v));
                REG_DIR_Y:       dir_y   = longint'($signed(v));
                REG_PLANE_X:     plane_x = longint'($signed(v));
                REG_PLANE_Y:     plane_y = longint'($signed(v));
                REG_VIEW_WIDTH:  view_w  = v[10:0];
                REG_VIEW_HEIGHT: view_h  = v[9:0];
                default: ;
            endcase
        endfunction

        function longint step_length(longint r);
            longint a, d;
            a = (r < 0) ? -r : r;
            if (a == 0) return RAY_INF;
            d = (longint'(1) << 22) / a;
            return (d > 65535) ? 65535 : d;
        endfunction

        function longint first_crossing(longint p, longint r, longint delta);
            longint f;
            if (delta >= RAY_INF) return RAY_INF;
            f = p & 255;
            if (r >= 0) f = 256 - f;
            return (f * delta) >>> 8;
        endfunction

        // Walk the ray through the map and work out what the block must return
        function cast_result_t trace_column(logic [10:0] col);
            cast_result_t res;
            longint vw, scan, rx, ry, dx, dy, sx, sy, mx, my, hit_dist, t;
            logic [7:0] cell_val;
            logic [1:0] c;
            bit xs;
            vw = (view_w == 0) ? 1 : view_w;
            scan = ((2 * longint'(col)) << 14) / vw - 16384;
            rx = dir_x + ((plane_x * scan) >>> 14);
            ry = dir_y + ((plane_y * scan) >>> 14);
            dx = step_length(rx);
            dy = step_length(ry);
            sx = first_crossing(cam_x, rx, dx);
            sy = first_crossing(cam_y, ry, dy);
            mx = cam_x >> 8;
            my = cam_y >> 8;
            res = '{column: col, code: 0, side: 0, distance: 0, tex: 0, height: 0,
                    status: CAST_STEP_LIMIT};
            hit_dist = 0;
            for (int n = 0; n < MAX_STEPS_DEF; n++) begin
                if (mx < 0 || my < 0 || mx >= GRID_SIDE_DEF || my >= GRID_SIDE_DEF ||
                    my * GRID_SIDE_DEF + mx >= MAP_DEPTH) begin
                    res.status = CAST_LEFT_GRID;
                    break;
                end
                cell_val = map_cells[my * GRID_SIDE_DEF + mx];
                xs = sx < sy;
                if (xs) c = (rx >= 0) ? cell_val[5:4] : cell_val[1:0];
                else    c = (ry >= 0) ? cell_val[7:6] : cell_val[3:2];
                if (c != 0) begin
                    res.code = c;
                    res.side = !xs;
                    hit_dist = xs ? sx : sy;
                    res.status = CAST_HIT;
                    break;
                end
                if (xs) begin
                    if (sx < RAY_INF) sx += dx;
                    mx += (rx < 0) ? -1 : 1;
                end else begin
                    if (sy < RAY_INF) sy += dy;
                    my += (ry < 0) ? -1 : 1;
                end
            end
            if (res.status == CAST_HIT) begin
                if (hit_dist > 65535) hit_dist = 65535;
                res.distance = hit_dist[15:0];
                if (res.side == 0) t = cam_y + ((hit_dist * ry) >>> 14);
                else               t = cam_x + ((hit_dist * rx) >>> 14);
                res.tex = t[7:0];
                if (hit_dist == 0) begin
                    res.height = 16'hFFFF;
                end else begin
                    t = ((HEIGHT_SCALE_DEF * view_h) << 8) / hit_dist;
                    res.height = (t > 65535) ? 16'hFFFF : t[15:0];
                end
            end
            return res;
        endfunction

        // Apply an accepted input transaction
        function void note_request(bit req, logic [7:0] idx, logic [7:0] walls,
                                   logic [10:0] col);
            if (req == REQ_LOAD) map_cells[idx] = walls;
            else pending_casts.push_back(trace_column(col));
        endfunction

        // Compare one output transaction against the oldest expected cast
        function void check_result(logic [OUT_DATA_W-1:0] d);
            cast_result_t e;
            if (pending_casts.size() == 0) begin
                $display("%0t unexpected result, got %h", $time, d);
                errors++;
                return;
            end
            e = pending_casts.pop_front();
            casts_done++;
            if (e.status == CAST_HIT) hits++; else misses++;
            compare("out_column",     e.column,   d[10:0]);
            compare("wall_code",      e.code,     d[12:11]);
            compare("hit_side",       e.side,     d[13]);
            compare("wall_distance",  e.distance, d[29:14]);
            compare("texture_offset", e.tex,      d[37:30]);
            compare("wall_height",    e.height,   d[53:38]);
            compare("cast_status",    e.status,   d[55:54]);
        endfunction

        function void compare(string name, longint exp_v, longint got_v);
            if (exp_v != got_v) begin
                $display("%0t %s mismatch: expected %0d actual %0d",
                         $time, name, exp_v, got_v);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    raycast_scoreboard sb = new();
    bit     send_idle_on = 1'b1;
    bit     recv_idle_on = 1'b1;
    int     recv_stall_left = 0;
    int     wall_density = 30;
    longint cycles = 0;

    grid_raycast_column dut (.*);

    always #6 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one
    function int pick_gap();
        if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function logic [7:0] random_cell();
        logic [7:0] w;
        for (int k = 0; k < 4; k++)
            w[2*k +: 2] = ($urandom_range(0, 99) < wall_density) ?
                          2'($urandom_range(1, 3)) : 2'd0;
        return w;
    endfunction

    // Collect and check output transactions, stall at random
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("%0t timeout with %0d casts outstanding", $time,
                     sb.pending_casts.size());
            $display("[FAIL] regression broken");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        if (recv_stall_left > 0) begin
            m_axis_tready <= 1'b0;
            recv_stall_left <= recv_stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (recv_idle_on && $urandom_range(0, 3) == 0) recv_stall_left <= pick_gap();
        end
    end

    task automatic send_item(bit req, logic [7:0] idx, logic [7:0] walls, logic [10:0] col);
        int gap;
        gap = (send_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {5'd0, col, walls, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(req, idx, walls, col);
    endtask

    task automatic load_cell(logic [7:0] idx, logic [7:0] walls);
        send_item(REQ_LOAD, idx, walls, 11'($urandom_range(0, 2047)));
    endtask

    task automatic cast_column(logic [10:0] col);
        send_item(REQ_CAST, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), col);
    endtask

    // Lower valid, then hold until every cast has come back and the block settles
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_casts.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write enable stays high across a burst; the caller lowers it
    task automatic cfg_write(t_cfg_reg r, logic [15:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= r;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.write_reg(r, v);
    endtask

    task automatic camera(int px, int py, int dx, int dy, int plx, int ply, int vw, int vh);
        cfg_write(REG_POS_X, 16'(px));
        cfg_write(REG_POS_Y, 16'(py));
        cfg_write(REG_DIR_X, 16'(dx));
        cfg_write(REG_DIR_Y, 16'(dy));
        cfg_write(REG_PLANE_X, 16'(plx));
        cfg_write(REG_PLANE_Y, 16'(ply));
        cfg_write(REG_VIEW_WIDTH, 16'(vw));
        cfg_write(REG_VIEW_HEIGHT, 16'(vh));
        i_cfg_we <= 1'b0;
    endtask

    function int pick_component();
        case ($urandom_range(0, 5))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            default: return $signed(16'($urandom_range(0, 65535))) / 2;
        endcase
    endfunction

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the whole map first so that no cast ever reads an unwritten cell
        for (int i = 0; i < MAP_DEPTH; i++) load_cell(8'(i), random_cell());
        load_cell(8'd0, 8'hFF);
        load_cell(8'd255, 8'h00);

        // Directed: reset camera, screen edges, center ray with zero y component
        cast_column(11'd0);
        cast_column(11'd320);
        cast_column(11'd639);
        cast_column(11'd1024);
        drain();
        // Zero x ray component at the center column
        camera(384, 384, 0, 16384, 10813, 0, 640, 480);
        cast_column(11'd320);
        cast_column(11'd1);
        drain();
        // Both components zero, then camera in corners and the field extremes
        camera(0, 0, 0, 0, 0, 0, 1, 1);
        cast_column(11'd0);
        cast_column(11'd1024);
        drain();
        camera(4095, 4095, -32768, -32768, 32767, -32768, 1024, 1023);
        cast_column(11'd0);
        cast_column(11'd512);
        cast_column(11'd1024);
        cast_column(11'd2047);
        drain();
        camera(2048, 128, 32767, 32767, -32768, 32767, 1024, 1023);
        cast_column(11'd0);
        cast_column(11'd1023);
        drain();

        // Random phases: new camera and wall density, mixed loads and casts
        for (int p = 0; p < N_PHASES; p++) begin
            send_idle_on = (p % 3) != 1;
            recv_idle_on = (p % 3) != 2;
            wall_density = (p == 3) ? 0 : $urandom_range(15, 60);
            camera($urandom_range(0, 4095), $urandom_range(0, 4095),
                   pick_component(), pick_component(), pick_component(), pick_component(),
                   (p % 4 == 0) ? 1 : $urandom_range(1, 1024),
                   (p % 4 == 1) ? 1023 : $urandom_range(1, 1023));
            for (int n = 0; n < PHASE_LEN; n++) begin
                if ($urandom_range(0, 99) < 20) load_cell(8'($urandom_range(0, 255)),
                                                         random_cell());
                else cast_column(11'($urandom_range(0, 1024)));
            end
            drain();
        end

        $display("casts checked: %0d (%0d hits, %0d misses) over %0d camera settings",
                 sb.casts_done, sb.hits, sb.misses, N_PHASES + 5);
        if (sb.errors == 0 && sb.pending_casts.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/grc_pkg.sv
rtl/grc_divider.sv
rtl/grc_datapath.sv
rtl/grc_ctrl.sv
rtl/grid_raycast_column.sv
test/tb.sv
